/* hdl/char_lcd_nibble_write_sequencer_assert.svh */
// Assertion macros used by the sequencer checker.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

// check cons in the same cycle as ante
`define LCDSEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcdseq: same-cycle check failed");

// check cons in the cycle after ante
`define LCDSEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcdseq: next-cycle check failed");

`endif

/* hdl/lcdseq_pkg.sv */
// Types and codes of the character LCD nibble write sequencer.
package lcdseq_pkg;

   localparam int TDATA_W_REQ = 16;
   localparam int TDATA_W_RSP = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SETUP_TICKS       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STROBE_HIGH_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STROBE_LOW_TICKS  = 2'd2;

   localparam logic [7:0] TICKS_RESET = 8'd3;

   typedef enum logic [1:0] {
      FN_TICK   = 2'd0,
      FN_BYTE   = 2'd1,
      FN_NIBBLE = 2'd2,
      FN_POS    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SETUP = 2'd1,
      PH_HIGH  = 2'd2,
      PH_LOW   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] setup_ticks;
      logic [7:0] strobe_high_ticks;
      logic [7:0] strobe_low_ticks;
   } cfg_type;

   typedef struct packed {
      func_type   func;
      logic       reg_select;
      logic [7:0] data_byte;
      logic       row;
      logic [5:0] column;
   } req_type;

endpackage

/* hdl/lcdseq_csr.sv */
// Timing registers of the sequencer, written through the plain write port.
module lcdseq_csr
   import lcdseq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_ticks       <= TICKS_RESET;
         cfg_ff.strobe_high_ticks <= TICKS_RESET;
         cfg_ff.strobe_low_ticks  <= TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SETUP_TICKS:       cfg_ff.setup_ticks       <= csr_wdata;
            CSR_STROBE_HIGH_TICKS: cfg_ff.strobe_high_ticks <= csr_wdata;
            CSR_STROBE_LOW_TICKS:  cfg_ff.strobe_low_ticks  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/lcdseq_in_stage.sv */
// Input register stage: takes a request word and holds it for the engine.
module lcdseq_in_stage
   import lcdseq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_W_REQ-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   take,
   output logic                   item_valid,
   output req_type                item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.func       <= func_type'(req_tuser);
         item_ff.reg_select <= req_tdata[0];
         item_ff.data_byte  <= req_tdata[8:1];
         item_ff.row        <= req_tdata[9];
         item_ff.column     <= req_tdata[15:10];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* hdl/lcdseq_engine.sv */
// Nibble phase sequencer state and the registered result word.
module lcdseq_engine
   import lcdseq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   item_valid,
   input  req_type                item,
   output logic                   take,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_W_RSP-1:0] rsp_tdata
);

   phase_type  phase_ff,   phase_in;
   logic [7:0] count_ff,   count_in;
   logic [7:0] held_ff,    held_in;
   logic       pending_ff, pending_in;
   logic       enable_ff,  enable_in;
   logic       select_ff,  select_in;
   logic [3:0] data_ff,    data_in;
   logic       rsp_valid_ff;
   logic [TDATA_W_RSP-1:0] rsp_data_ff, rsp_data_in;
   logic       rejected;
   logic       done;
   logic [7:0] limit;

   assign take = item_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      case (phase_ff)
         PH_SETUP: limit = cfg.setup_ticks;
         PH_HIGH:  limit = cfg.strobe_high_ticks;
         default:  limit = cfg.strobe_low_ticks;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      held_in    = held_ff;
      pending_in = pending_ff;
      enable_in  = enable_ff;
      select_in  = select_ff;
      data_in    = data_ff;
      rejected   = 1'b0;
      done       = 1'b0;
      case (item.func)
         FN_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (count_ff == limit) begin
                  count_in = 8'd0;
                  case (phase_ff)
                     PH_SETUP: begin
                        enable_in = 1'b1;
                        phase_in  = PH_HIGH;
                     end
                     PH_HIGH: begin
                        enable_in = 1'b0;
                        phase_in  = PH_LOW;
                     end
                     default: begin
                        if (pending_ff) begin
                           pending_in = 1'b0;
                           enable_in  = 1'b0;
                           data_in    = held_ff[3:0];
                           phase_in   = PH_SETUP;
                        end else begin
                           data_in  = 4'd0;
                           phase_in = PH_IDLE;
                           done     = 1'b1;
                        end
                     end
                  endcase
               end else begin
                  count_in = count_ff + 8'd1;
               end
            end
         end
         default: begin
            if (phase_ff != PH_IDLE) begin
               rejected = 1'b1;
            end else begin
               enable_in = 1'b0;
               count_in  = 8'd0;
               phase_in  = PH_SETUP;
               case (item.func)
                  FN_POS: begin
                     held_in    = {1'b1, item.row, item.column};
                     select_in  = 1'b0;
                     pending_in = 1'b1;
                     data_in    = {1'b1, item.row, item.column[5:4]};
                  end
                  FN_BYTE: begin
                     held_in    = item.data_byte;
                     select_in  = item.reg_select;
                     pending_in = 1'b1;
                     data_in    = item.data_byte[7:4];
                  end
                  default: begin
                     held_in    = {4'd0, item.data_byte[3:0]};
                     select_in  = item.reg_select;
                     pending_in = 1'b0;
                     data_in    = item.data_byte[3:0];
                  end
               endcase
            end
         end
      endcase
      rsp_data_in = {7'd0, done, rejected, (phase_in != PH_IDLE), data_in,
                     select_in, enable_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= 8'd0;
         held_ff      <= 8'd0;
         pending_ff   <= 1'b0;
         enable_ff    <= 1'b0;
         select_ff    <= 1'b0;
         data_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            held_ff    <= held_in;
            pending_ff <= pending_in;
            enable_ff  <= enable_in;
            select_ff  <= select_in;
            data_ff    <= data_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hdl/char_lcd_nibble_write_sequencer.sv */
// Top level of the character LCD 4-bit nibble write sequencer.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_tvalid/tready    | tuser func, tdata request fields
//   rsp     | out       | rsp_tvalid/tready    | tdata pin levels and status
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// One word per cycle sustained while rsp is not stalled; a word taken on req
// lands in the input register and passes to rsp through the result register.
// Reset is synchronous: timing registers return to 3, phase to idle, pins low.
// A stalled rsp holds its word; req keeps taking one more word into the input
// register, then stalls until rsp drains.
module char_lcd_nibble_write_sequencer
   import lcdseq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [0] reg_select, [8:1] data_byte, [9] row, [15:10] column
   input  logic [TDATA_W_REQ-1:0] req_tdata,
   // [1:0] func
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] enable_line, [1] select_line, [5:2] data_lines, [6] busy_res,
   // [7] rejected, [8] done_res, [15:9] zero
   output logic [TDATA_W_RSP-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type item;
   logic    item_valid;
   logic    take;

   lcdseq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcdseq_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   lcdseq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hdl/lcdseq_checker.sv */
// Port-level checks of the sequencer and their bind to the top level.
`include "char_lcd_nibble_write_sequencer_assert.svh"

module lcdseq_checker
   import lcdseq_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [TDATA_W_RSP-1:0] rsp_tdata
);

   logic       stalled;
   logic       enable_line;
   logic [3:0] data_lines;
   logic       busy_res;
   logic       rejected;
   logic       done_res;
   logic       pins_low;

   assign stalled     = rsp_tvalid && !rsp_tready;
   assign enable_line = rsp_tdata[0];
   assign data_lines  = rsp_tdata[5:2];
   assign busy_res    = rsp_tdata[6];
   assign rejected    = rsp_tdata[7];
   assign done_res    = rsp_tdata[8];
   assign pins_low    = !enable_line && (data_lines == 4'd0);

   `LCDSEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata))
   `LCDSEQ_ASSERT_NOW(a_reject_busy, clock, reset, rsp_tvalid && rejected, busy_res && !done_res)
   `LCDSEQ_ASSERT_NOW(a_done_idle, clock, reset, rsp_tvalid && done_res, !busy_res && pins_low)
   `LCDSEQ_ASSERT_NOW(a_enable_busy, clock, reset, rsp_tvalid && enable_line, busy_res)

endmodule

bind char_lcd_nibble_write_sequencer lcdseq_checker u_lcdseq_checker (.*);
